/* rtl/core/montgomery_modmul_32_top_defines.svh */
// ---------------------------------------------------------------------------
// Montgomery multiplier assertion macros
// Concurrent assertion wrappers shared by the multiplier RTL files.
// ---------------------------------------------------------------------------
`ifndef MONTGOMERY_MODMUL_32_TOP_DEFINES_SVH
`define MONTGOMERY_MODMUL_32_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define MONTMM_ASSERT(name, clk, rstn, prop) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("montmm assertion failed");
`define MONTMM_ASSERT_RST(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("montmm reset assertion failed");
`else
`define MONTMM_ASSERT(name, clk, rstn, prop)
`define MONTMM_ASSERT_RST(name, clk, prop)
`endif

`endif

/* rtl/core/montmm_pkg.sv */
// ---------------------------------------------------------------------------
// Montgomery multiplier package
// Widths, register indexes, reset values and the cell payload type.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package montmm_pkg;

    localparam int RES_W     = 31;
    localparam int WORD_W    = 32;
    localparam int PROD_W    = 64;
    localparam int T_W       = 62;
    localparam int CFG_IDX_W = 1;
    localparam int IN_DATA_W = 64;
    localparam int OUT_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEG_INVERSE = 1'b1;

    localparam logic [RES_W-1:0]  MODULUS_RESET     = 31'd998244353;
    localparam logic [WORD_W-1:0] NEG_INVERSE_RESET = 32'd998244351;

    typedef struct packed {
        logic [T_W-1:0]    t;
        logic [PROD_W-1:0] p;
    } cell_data_t;

endpackage

`default_nettype wire

/* rtl/core/montmm_cell.sv */
// ---------------------------------------------------------------------------
// Montgomery multiplier cell
// One pipeline cell: registers a 32 by 32 product and carries the wide product.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "montgomery_modmul_32_top_defines.svh"

module montmm_cell (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [montmm_pkg::WORD_W-1:0] in_x,
    input  wire logic [montmm_pkg::WORD_W-1:0] in_y,
    input  wire logic [montmm_pkg::T_W-1:0]    in_t,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output montmm_pkg::cell_data_t             out_data
);

    logic                   valid_reg;
    montmm_pkg::cell_data_t data_reg;
    montmm_pkg::cell_data_t data_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        data_next.t = in_t;
        data_next.p = {{montmm_pkg::WORD_W{1'b0}}, in_x} * {{montmm_pkg::WORD_W{1'b0}}, in_y};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    `MONTMM_ASSERT(a_cell_hold, aclk, aresetn,
        out_valid && !out_ready |=> out_valid && $stable(out_data))

endmodule

`default_nettype wire

/* rtl/core/montmm_reduce.sv */
// ---------------------------------------------------------------------------
// Montgomery multiplier reduction
// Adds the correction product, drops the low word and subtracts the modulus at most once.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "montgomery_modmul_32_top_defines.svh"

module montmm_reduce (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire montmm_pkg::cell_data_t        in_data,
    input  wire logic [montmm_pkg::RES_W-1:0]  modulus,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [montmm_pkg::RES_W-1:0]       out_residue
);

    logic                              sum_valid_reg;
    logic [montmm_pkg::WORD_W-1:0]     sum_hi_reg;
    logic [montmm_pkg::PROD_W-1:0]     sum_next;
    logic                              sum_ready;
    logic                              res_valid_reg;
    logic [montmm_pkg::RES_W-1:0]      res_reg;
    logic [montmm_pkg::RES_W-1:0]      res_next;
    logic [montmm_pkg::WORD_W-1:0]     mod_ext;
    logic [montmm_pkg::WORD_W-1:0]     diff;

    assign sum_next  = {2'b00, in_data.t} + in_data.p;
    assign in_ready  = !sum_valid_reg || sum_ready;
    assign sum_ready = !res_valid_reg || out_ready;

    assign mod_ext = {1'b0, modulus};
    assign diff    = sum_hi_reg - mod_ext;

    always_comb begin
        if (sum_hi_reg >= mod_ext) begin
            res_next = diff[montmm_pkg::RES_W-1:0];
        end else begin
            res_next = sum_hi_reg[montmm_pkg::RES_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                sum_valid_reg <= in_valid;
            end
            if (sum_ready) begin
                res_valid_reg <= sum_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            sum_hi_reg <= sum_next[montmm_pkg::PROD_W-1:montmm_pkg::WORD_W];
        end
        if (sum_valid_reg && sum_ready) begin
            res_reg <= res_next;
        end
    end

    assign out_valid   = res_valid_reg;
    assign out_residue = res_reg;

    `MONTMM_ASSERT_RST(a_reduce_reset_empty, aclk, !aresetn |=> !out_valid)

endmodule

`default_nettype wire

/* rtl/core/montgomery_modmul_32_top.sv */
// ---------------------------------------------------------------------------
// Montgomery modular multiplier, R = 2^32
// Streams a*b*2^-32 mod modulus through a row of multiplier cells.
// ---------------------------------------------------------------------------
// Channel   Direction  Payload (low bits first)
// s_        in         operand_a[30:0], operand_b[61:31], zero pad to 64
// m_        out        product_residue[30:0], zero pad to 32
// cfg_      in         index 0 modulus, index 1 neg_inverse
//
// One request is accepted per cycle unless a stall on m_ has backed up to the first cell.
// Each result passes through three multiplier cells and two reduction stages.
// Reset clears all valid flags and loads the default modulus and inverse.
// A stall on m_ holds each stage only while the stage after it is full.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "montgomery_modmul_32_top_defines.svh"

module montgomery_modmul_32_top (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // operand_a, operand_b
    input  wire logic [montmm_pkg::IN_DATA_W-1:0]  s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // product_residue
    output logic [montmm_pkg::OUT_DATA_W-1:0]      m_tdata,
    input  wire logic                              cfg_wen,
    input  wire logic [montmm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [montmm_pkg::WORD_W-1:0]     cfg_wdata
);

    logic [montmm_pkg::RES_W-1:0]  modulus_reg;
    logic [montmm_pkg::WORD_W-1:0] neg_inverse_reg;

    logic                   c0_valid, c0_ready;
    logic                   c1_valid, c1_ready;
    logic                   c2_valid, c2_ready;
    montmm_pkg::cell_data_t c0_data, c1_data, c2_data;
    logic [montmm_pkg::RES_W-1:0] residue;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg     <= montmm_pkg::MODULUS_RESET;
            neg_inverse_reg <= montmm_pkg::NEG_INVERSE_RESET;
        end else if (cfg_wen) begin
            unique case (cfg_index)
                montmm_pkg::CFG_MODULUS: begin
                    modulus_reg <= cfg_wdata[montmm_pkg::RES_W-1:0];
                end
                montmm_pkg::CFG_NEG_INVERSE: begin
                    neg_inverse_reg <= cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    montmm_cell u_cell_ab (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_x      ({1'b0, s_tdata[montmm_pkg::RES_W-1:0]}),
        .in_y      ({1'b0, s_tdata[2*montmm_pkg::RES_W-1:montmm_pkg::RES_W]}),
        .in_t      ({montmm_pkg::T_W{1'b0}}),
        .out_valid (c0_valid),
        .out_ready (c0_ready),
        .out_data  (c0_data)
    );

    montmm_cell u_cell_u (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (c0_valid),
        .in_ready  (c0_ready),
        .in_x      (c0_data.p[montmm_pkg::WORD_W-1:0]),
        .in_y      (neg_inverse_reg),
        .in_t      (c0_data.p[montmm_pkg::T_W-1:0]),
        .out_valid (c1_valid),
        .out_ready (c1_ready),
        .out_data  (c1_data)
    );

    montmm_cell u_cell_um (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (c1_valid),
        .in_ready  (c1_ready),
        .in_x      (c1_data.p[montmm_pkg::WORD_W-1:0]),
        .in_y      ({1'b0, modulus_reg}),
        .in_t      (c1_data.t),
        .out_valid (c2_valid),
        .out_ready (c2_ready),
        .out_data  (c2_data)
    );

    montmm_reduce u_reduce (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (c2_valid),
        .in_ready    (c2_ready),
        .in_data     (c2_data),
        .modulus     (modulus_reg),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_residue (residue)
    );

    assign m_tdata = {1'b0, residue};

    `MONTMM_ASSERT(a_top_ready_chain, aclk, aresetn, m_tready |-> s_tready)
    `MONTMM_ASSERT(a_top_flow, aclk, aresetn,
        c0_valid && c1_valid && c2_valid && !c2_ready |-> !c0_ready)

endmodule

`default_nettype wire

/* bench/tb.sv */
// ---------------------------------------------------------------------------
// Montgomery multiplier stream testbench
// Drives operand pairs into montgomery_modmul_32_top under several modulus
// and inverse settings, predicts each reduced product in the bench, and
// compares every returned residue in order while both sides idle at random.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    localparam int PHASE_COUNT = 12;
    localparam int PHASE_ITEMS = 130;
    localparam int DIRECTED_ROWS = 14;
    localparam int DRAIN_CYCLES = 10;
    localparam bit [30:0] RES_MAX = 31'h7FFF_FFFF;

    typedef struct packed {
        bit [30:0] a;
        bit [30:0] b;
        bit        known;
        bit [30:0] residue;
    } directed_row_t;

    logic                              aclk;
    logic                              aresetn = 1'b0;
    logic                              s_tvalid = 1'b0;
    logic                              s_tready;
    logic [montmm_pkg::IN_DATA_W-1:0]  s_tdata = '0;
    logic                              m_tvalid;
    logic                              m_tready = 1'b0;
    logic [montmm_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                              cfg_wen = 1'b0;
    logic [montmm_pkg::CFG_IDX_W-1:0]  cfg_index = montmm_pkg::CFG_MODULUS;
    logic [montmm_pkg::WORD_W-1:0]     cfg_wdata = '0;

    bit [30:0] modulus_reg = montmm_pkg::MODULUS_RESET;
    bit [31:0] neg_inverse_reg = montmm_pkg::NEG_INVERSE_RESET;
    bit [30:0] residue_q[$];
    int        mismatch_count = 0;
    int        stall_pct = 0;
    int        holdoff_request = 0;
    int        holdoff_left = 0;

    // With the reset modulus, 301989884 is 2^32 mod modulus, so it cancels the
    // Montgomery factor and the product equals the other operand.
    directed_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
        '{31'd0,          31'd0,          1'b1, 31'd0},
        '{31'd0,          RES_MAX,        1'b1, 31'd0},
        '{RES_MAX,        31'd0,          1'b1, 31'd0},
        '{31'd301989884,  31'd1,          1'b1, 31'd1},
        '{31'd301989884,  31'd998244352,  1'b1, 31'd998244352},
        '{31'd1,          31'd301989884,  1'b1, 31'd1},
        '{31'd1,          31'd1,          1'b0, 31'd0},
        '{31'd998244352,  31'd998244352,  1'b0, 31'd0},
        '{RES_MAX,        RES_MAX,        1'b0, 31'd0},
        '{31'd998244353,  31'd1,          1'b0, 31'd0},
        '{31'h5555_5555,  31'h2AAA_AAAA,  1'b0, 31'd0},
        '{31'h2AAA_AAAA,  31'h5555_5555,  1'b0, 31'd0},
        '{31'd1,          RES_MAX,        1'b0, 31'd0},
        '{31'd998244353,  31'd998244353,  1'b0, 31'd0}
    };

    montgomery_modmul_32_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    function automatic bit [30:0] predict_residue(bit [30:0] a, bit [30:0] b,
                                                  bit [30:0] m, bit [31:0] ninv);
        bit [63:0] a64;
        bit [63:0] b64;
        bit [63:0] m64;
        bit [63:0] t;
        bit [63:0] u64;
        bit [63:0] sum;
        bit [31:0] u;
        bit [31:0] s;
        a64 = a;
        b64 = b;
        m64 = m;
        t = a64 * b64;
        u = t[31:0] * ninv;
        u64 = u;
        sum = t + u64 * m64;
        s = sum[63:32];
        if (s >= {1'b0, m}) begin
            s = s - {1'b0, m};
        end
        return s[30:0];
    endfunction

    // Newton iteration for the inverse mod 2^32; each step doubles the good bits.
    function automatic bit [31:0] neg_inverse_of(bit [31:0] m);
        bit [31:0] x;
        x = m;
        repeat (5) x = x * (32'd2 - m * x);
        return -x;
    endfunction

    function automatic bit [30:0] pick_operand(bit [30:0] m);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 3) return 31'd0;
        if (r < 5) return RES_MAX;
        if (r < 7) return m;
        if (r < 9 && m != 0) return m - 31'd1;
        if (r < 85 && m != 0) return 31'($urandom_range({1'b0, m - 31'd1}));
        return 31'($urandom);
    endfunction

    task automatic send_product(bit [30:0] a, bit [30:0] b, bit known,
                                bit [30:0] residue, int idle_pct);
        int gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, b, a};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        residue_q.push_back(known ? residue
                                  : predict_residue(a, b, modulus_reg, neg_inverse_reg));
    endtask

    task automatic wait_drain();
        do @(posedge aclk); while (residue_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic load_registers(bit [31:0] modulus_word, bit [31:0] ninv_word);
        cfg_wen <= 1'b1;
        cfg_index <= montmm_pkg::CFG_MODULUS;
        cfg_wdata <= modulus_word;
        @(posedge aclk);
        cfg_index <= montmm_pkg::CFG_NEG_INVERSE;
        cfg_wdata <= ninv_word;
        @(posedge aclk);
        cfg_wen <= 1'b0;
        modulus_reg = modulus_word[30:0];
        neg_inverse_reg = ninv_word;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (holdoff_request > 0) begin
                holdoff_left = holdoff_request;
                holdoff_request = 0;
            end
            if (holdoff_left > 0) begin
                m_tready <= 1'b0;
                holdoff_left--;
            end else begin
                m_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        bit [30:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (residue_q.size() == 0) begin
                mismatch_count++;
                $error("unexpected result: product_residue actual %0d", m_tdata[30:0]);
            end else begin
                want = residue_q.pop_front();
                if (m_tdata[30:0] !== want) begin
                    mismatch_count++;
                    $error("product_residue expected %0d actual %0d", want, m_tdata[30:0]);
                end
                if (m_tdata[31] !== 1'b0) begin
                    mismatch_count++;
                    $error("m_tdata pad expected 0 actual %b", m_tdata[31]);
                end
            end
        end
    end

    initial begin
        bit [31:0] modulus_words [PHASE_COUNT];
        bit [31:0] ninv_words [PHASE_COUNT];
        bit [31:0] odd;
        int        idle_pct;

        modulus_words[0] = {1'b0, montmm_pkg::MODULUS_RESET};
        ninv_words[0] = montmm_pkg::NEG_INVERSE_RESET;
        modulus_words[1] = 32'd3;
        ninv_words[1] = neg_inverse_of(32'd3);
        modulus_words[2] = 32'h7FFF_FFFF;
        ninv_words[2] = neg_inverse_of(32'h7FFF_FFFF);
        // Bit 31 of the write data lies outside the modulus and must be dropped.
        odd = $urandom_range(32'h7FFF_FFFF, 5) | 32'd1;
        modulus_words[3] = odd | 32'h8000_0000;
        ninv_words[3] = neg_inverse_of(odd);
        odd = $urandom_range(32'h7FFF_FFFF, 5) | 32'd1;
        modulus_words[4] = odd;
        ninv_words[4] = neg_inverse_of(odd);
        odd = $urandom_range(1000, 5) | 32'd1;
        modulus_words[5] = odd;
        ninv_words[5] = neg_inverse_of(odd);
        modulus_words[6] = $urandom_range(32'h7FFF_FFFF, 5) | 32'd1;
        ninv_words[6] = $urandom;
        modulus_words[7] = $urandom_range(32'h7FFF_FFFF, 4) & 32'h7FFF_FFFE;
        ninv_words[7] = $urandom;
        modulus_words[8] = 32'd0;
        ninv_words[8] = 32'hFFFF_FFFF;
        modulus_words[9] = 32'h4000_0001;
        ninv_words[9] = neg_inverse_of(32'h4000_0001);
        modulus_words[10] = 32'h7FFF_FFFF;
        ninv_words[10] = 32'd0;
        odd = $urandom_range(32'h7FFF_FFFF, 5) | 32'd1;
        modulus_words[11] = odd;
        ninv_words[11] = neg_inverse_of(odd);

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            send_product(directed_rows[i].a, directed_rows[i].b, directed_rows[i].known,
                         directed_rows[i].residue, 0);
        end
        s_tvalid <= 1'b0;
        wait_drain();

        for (int p = 0; p < PHASE_COUNT; p++) begin
            load_registers(modulus_words[p], ninv_words[p]);
            case (p % 4)
                0: begin
                    idle_pct = 0;
                    stall_pct = 0;
                end
                1: begin
                    idle_pct = 85;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct = 0;
                    stall_pct = 85;
                end
                default: begin
                    idle_pct = 10;
                    stall_pct = 10;
                end
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (p == 0 && i == 30) begin
                    holdoff_request = 80;
                end
                if (p == 4 && i == 50) begin
                    s_tvalid <= 1'b0;
                    wait_drain();
                end
                send_product(pick_operand(modulus_reg), pick_operand(modulus_reg),
                             1'b0, 31'd0, idle_pct);
            end
            s_tvalid <= 1'b0;
            wait_drain();
        end

        if (mismatch_count == 0 && residue_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/montmm_pkg.sv
rtl/core/montmm_cell.sv
rtl/core/montmm_reduce.sv
rtl/core/montgomery_modmul_32_top.sv
bench/tb.sv
